### hw/rtl/trab_pkg.sv
// shared types, constants and helpers for the triangle raster blender
`timescale 1ns / 1ps

package trab_pkg;

    localparam int DEF_PIC_WIDTH  = 128;
    localparam int DEF_PIC_HEIGHT = 128;
    localparam int DEF_SPAN_ROWS  = 512;

    localparam int COORD_W = 9;
    localparam int POS_W   = 10;
    localparam int ERR_W   = 12;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 24;
    localparam int IN_W    = 88;

    localparam logic [1:0] KIND_PAINT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    // unused kind, changes nothing
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [PIX_W-1:0] PIX_WHITE = '1;
    localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pt_t;

    typedef struct packed {
        pt_t v1;
        pt_t v2;
    } seg_t;

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [CH_W-1:0] div255(input logic [16:0] v);
        logic [16:0] t;
        t = v + 17'd1 + (v >> 8);
        return t[15:8];
    endfunction

endpackage

### hw/rtl/triangle_raster_alpha_blend.sv
// top level: triangle scanline fill with alpha blend into an rgb frame store
//
// input beats on s_*: tuser carries the kind (paint, read, clear), tdata the
// three vertices and the rgba paint colour. every input beat gives exactly one
// output beat on m_*: the pixel read for a read beat, black otherwise or when
// the read lies off the picture.
// one item is handled at a time. a read passes the setup and done states, and the
// next beat is taken once the block is back in idle; a clear sweeps the whole
// frame store (one frame-store write per cycle) and then passes the done state.
// a paint sorts the edges and takes the cross product, then walks the tallest
// edge by bresenham steps into the span store, sets up each short edge, and for
// each walked point of a short edge reads the span limit, visits the span pixels
// and waits for the read, blend and write pipeline of the frame store to drain;
// a point whose row is not kept goes straight to that drain.
// after reset the frame store is swept to white, with s_tready low.
// a stalled receiver holds the result in the output register; the next item
// is accepted meanwhile but its result waits until the register is free.
`timescale 1ns / 1ps

module triangle_raster_alpha_blend #(
    parameter int PIC_WIDTH  = trab_pkg::DEF_PIC_WIDTH,
    parameter int PIC_HEIGHT = trab_pkg::DEF_PIC_HEIGHT,
    parameter int SPAN_ROWS  = trab_pkg::DEF_SPAN_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // ax, ay, bx, by_coord, cx, cy, paint_red, paint_green, paint_blue, paint_alpha
    input  logic [trab_pkg::IN_W-1:0]   s_tdata,
    // kind
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_red, read_green, read_blue
    output logic [trab_pkg::PIX_W-1:0]  m_tdata
);

    localparam int FB_DEPTH = PIC_WIDTH * PIC_HEIGHT;
    localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
    localparam int SP_AW    = $clog2(SPAN_ROWS);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_IDLE   = 12'b0000_0000_0010,
        ST_SETUP  = 12'b0000_0000_0100,
        ST_CROSS  = 12'b0000_0000_1000,
        ST_TINIT  = 12'b0000_0001_0000,
        ST_TALL   = 12'b0000_0010_0000,
        ST_FSET   = 12'b0000_0100_0000,
        ST_FPOINT = 12'b0000_1000_0000,
        ST_FLIM   = 12'b0001_0000_0000,
        ST_FRUN   = 12'b0010_0000_0000,
        ST_FDRAIN = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 kind_reg, kind_next;
    trab_pkg::pt_t              pts_reg [3];
    trab_pkg::pt_t              pts_next [3];
    logic [23:0]                col_reg, col_next;
    logic [7:0]                 alpha_reg, alpha_next;
    trab_pkg::seg_t             e_reg [3];
    trab_pkg::seg_t             e_next [3];
    logic signed [19:0]         prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic                       rs_reg, rs_next;
    logic signed [11:0]         err_reg, err_next;
    logic signed [9:0]          wx_reg, wx_next, wy_reg, wy_next;
    logic signed [9:0]          x2_reg, x2_next, y2_reg, y2_next;
    logic [9:0]                 dx_reg, dx_next, dy_reg, dy_next;
    logic                       sx_neg_reg, sx_neg_next;
    logic [9:0]                 row_reg, row_next;
    logic                       edge_reg, edge_next;
    logic signed [9:0]          lim_reg, lim_next;
    logic signed [9:0]          cur_reg, cur_next;
    logic [FB_AW-1:0]           clr_reg, clr_next;
    logic                       clr_item_reg, clr_item_next;
    logic                       hit_reg, hit_next;
    logic                       out_valid_reg, out_valid_next;
    logic [23:0]                out_data_reg, out_data_next;
    logic                       p1_valid_reg, p1_valid_next;
    logic [FB_AW-1:0]           p1_addr_reg, p1_addr_next;

    // memories
    logic [23:0]                fb_mem [FB_DEPTH];
    logic [23:0]                fb_q;
    logic                       fb_re, fb_we;
    logic [FB_AW-1:0]           fb_raddr, fb_waddr;
    logic [23:0]                fb_wdata;
    logic signed [9:0]          sp_mem [SPAN_ROWS];
    logic signed [9:0]          sp_q;
    logic                       sp_re, sp_we;
    logic [SP_AW-1:0]           sp_raddr, sp_waddr;
    logic signed [9:0]          sp_wdata;

    logic                       bl_valid;
    logic [FB_AW-1:0]           bl_addr;
    logic [23:0]                bl_pix;

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_mem[fb_waddr] <= fb_wdata;
        end
        if (fb_re)
        begin
            fb_q <= fb_mem[fb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_mem[sp_waddr] <= sp_wdata;
        end
        if (sp_re)
        begin
            sp_q <= sp_mem[sp_raddr];
        end
    end

    trab_blend #(
        .FB_AW (FB_AW)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .in_addr   (p1_addr_reg),
        .old_pix   (fb_q),
        .paint_pix (col_reg),
        .alpha     (alpha_reg),
        .out_valid (bl_valid),
        .out_addr  (bl_addr),
        .out_pix   (bl_pix)
    );

    // edge sort, stable on height
    trab_pkg::seg_t  raw_seg [3];
    trab_pkg::seg_t  srt_a [3];
    trab_pkg::seg_t  srt_b [3];
    trab_pkg::seg_t  srt_c [3];

    function automatic logic [9:0] seg_h(input trab_pkg::seg_t s);
        return 10'(10'(s.v2.y) - 10'(s.v1.y));
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(pts_reg[k].y) > $signed(pts_reg[(k + 1) % 3].y))
            begin
                raw_seg[k] = '{v1: pts_reg[(k + 1) % 3], v2: pts_reg[k]};
            end
            else
            begin
                raw_seg[k] = '{v1: pts_reg[k], v2: pts_reg[(k + 1) % 3]};
            end
        end
        srt_a = raw_seg;
        if (seg_h(raw_seg[1]) < seg_h(raw_seg[0]))
        begin
            srt_a[0] = raw_seg[1];
            srt_a[1] = raw_seg[0];
        end
        srt_b = srt_a;
        if (seg_h(srt_a[2]) < seg_h(srt_a[1]))
        begin
            srt_b[1] = srt_a[2];
            srt_b[2] = srt_a[1];
        end
        srt_c = srt_b;
        if (seg_h(srt_b[1]) < seg_h(srt_b[0]))
        begin
            srt_c[0] = srt_b[1];
            srt_c[1] = srt_b[0];
        end
    end

    // cross product operands
    trab_pkg::pt_t       rem_pt;
    logic signed [9:0]   lx, ly, rx, ry;
    logic signed [20:0]  cross_val;

    always_comb
    begin
        rem_pt = e_reg[0].v1;
        if (rem_pt == e_reg[2].v1 || rem_pt == e_reg[2].v2)
        begin
            rem_pt = e_reg[0].v2;
        end
        lx = 10'(e_reg[2].v2.x) - 10'(e_reg[2].v1.x);
        ly = 10'(e_reg[2].v2.y) - 10'(e_reg[2].v1.y);
        rx = 10'(rem_pt.x) - 10'(e_reg[2].v1.x);
        ry = 10'(rem_pt.y) - 10'(e_reg[2].v1.y);
        cross_val = 21'(prod_a_reg) - 21'(prod_b_reg);
    end

    // walk initialisation from the tall edge or the current short edge
    trab_pkg::seg_t      fseg, wseg;
    logic signed [9:0]   wi_ddx;
    logic [9:0]          wi_dx, wi_dy;

    always_comb
    begin
        fseg = edge_reg ? e_reg[1] : e_reg[0];
        if (fseg.v1.y == fseg.v2.y
            && ((rs_reg && $signed(fseg.v1.x) < $signed(fseg.v2.x))
                || (!rs_reg && $signed(fseg.v1.x) > $signed(fseg.v2.x))))
        begin
            fseg = '{v1: fseg.v2, v2: fseg.v1};
        end
        wseg   = (state_reg == ST_TINIT) ? e_reg[2] : fseg;
        wi_ddx = 10'(wseg.v1.x) - 10'(wseg.v2.x);
        wi_dx  = wi_ddx[9] ? 10'(-wi_ddx) : 10'(wi_ddx);
        wi_dy  = seg_h(wseg);
    end

    // one bresenham step
    logic signed [12:0]  e2, dxs, dys, nerr;
    logic                cond_x, cond_y, at_end;
    logic signed [9:0]   nx, ny;
    logic [9:0]          nrow;

    always_comb
    begin
        e2     = {err_reg, 1'b0};
        dxs    = $signed({3'b000, dx_reg});
        dys    = $signed({3'b000, dy_reg});
        cond_x = e2 > -dys;
        cond_y = e2 < dxs;
        nerr   = 13'(err_reg) - (cond_x ? dys : 13'sd0) + (cond_y ? dxs : 13'sd0);
        nx     = wx_reg + (cond_x ? (sx_neg_reg ? -10'sd1 : 10'sd1) : 10'sd0);
        ny     = wy_reg + (cond_y ? 10'sd1 : 10'sd0);
        nrow   = row_reg + (cond_y ? 10'd1 : 10'd0);
        at_end = (wx_reg == x2_reg) && (wy_reg == y2_reg);
    end

    function automatic logic row_ok(input logic [9:0] r);
        return {1'b0, r} < 11'(SPAN_ROWS);
    endfunction

    function automatic logic in_pic(input logic signed [9:0] x,
                                    input logic signed [9:0] y);
        return !x[9] && !y[9] && ({1'b0, x} < 11'(PIC_WIDTH))
               && ({1'b0, y} < 11'(PIC_HEIGHT));
    endfunction

    function automatic logic [FB_AW-1:0] pix_addr(input logic signed [9:0] x,
                                                  input logic signed [9:0] y);
        logic [17:0] a;
        a = 18'(y[7:0]) * 18'(PIC_WIDTH) + 18'(x[7:0]);
        return a[FB_AW-1:0];
    endfunction

    logic signed [9:0]  rd_x, rd_y;
    logic               run_on;

    assign rd_x   = 10'(pts_reg[0].x);
    assign rd_y   = 10'(pts_reg[0].y);
    assign run_on = rs_reg ? (cur_reg >= lim_reg) : (cur_reg <= lim_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pts_next       = pts_reg;
        col_next       = col_reg;
        alpha_next     = alpha_reg;
        e_next         = e_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        rs_next        = rs_reg;
        err_next       = err_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_neg_next    = sx_neg_reg;
        row_next       = row_reg;
        edge_next      = edge_reg;
        lim_next       = lim_reg;
        cur_next       = cur_reg;
        clr_next       = clr_reg;
        clr_item_next  = clr_item_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        p1_valid_next  = 1'b0;
        p1_addr_next   = p1_addr_reg;

        fb_re    = 1'b0;
        fb_raddr = pix_addr(cur_reg, wy_reg);
        fb_we    = bl_valid;
        fb_waddr = bl_addr;
        fb_wdata = bl_pix;
        sp_re    = 1'b0;
        sp_raddr = row_reg[SP_AW-1:0];
        sp_we    = 1'b0;
        sp_waddr = row_reg[SP_AW-1:0];
        sp_wdata = wx_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_waddr = clr_reg;
                fb_wdata = trab_pkg::PIX_WHITE;
                if (clr_reg == FB_AW'(FB_DEPTH - 1))
                begin
                    hit_next   = 1'b0;
                    state_next = clr_item_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = s_tuser;
                    pts_next[0] = '{x: s_tdata[8:0],   y: s_tdata[17:9]};
                    pts_next[1] = '{x: s_tdata[26:18], y: s_tdata[35:27]};
                    pts_next[2] = '{x: s_tdata[44:36], y: s_tdata[53:45]};
                    col_next    = s_tdata[77:54];
                    alpha_next  = s_tdata[85:78];
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                hit_next = 1'b0;
                unique case (kind_reg)
                    trab_pkg::KIND_PAINT:
                    begin
                        e_next     = srt_c;
                        state_next = ST_CROSS;
                    end
                    trab_pkg::KIND_READ:
                    begin
                        fb_re      = 1'b1;
                        fb_raddr   = pix_addr(rd_x, rd_y);
                        hit_next   = in_pic(rd_x, rd_y);
                        state_next = ST_DONE;
                    end
                    trab_pkg::KIND_CLEAR:
                    begin
                        clr_next      = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CROSS:
            begin
                prod_a_next = lx * ry;
                prod_b_next = ly * rx;
                state_next  = ST_TINIT;
            end
            ST_TINIT:
            begin
                rs_next     = cross_val[20];
                dx_next     = wi_dx;
                dy_next     = wi_dy;
                sx_neg_next = !($signed(wseg.v1.x) < $signed(wseg.v2.x));
                err_next    = 12'(wi_dx) - 12'(wi_dy);
                wx_next     = 10'(wseg.v1.x);
                wy_next     = 10'(wseg.v1.y);
                x2_next     = 10'(wseg.v2.x);
                y2_next     = 10'(wseg.v2.y);
                row_next    = '0;
                sp_we       = 1'b1;
                sp_waddr    = '0;
                sp_wdata    = 10'(wseg.v1.x);
                state_next  = ST_TALL;
            end
            ST_TALL:
            begin
                if (at_end)
                begin
                    if ($signed(e_reg[1].v1.y) < $signed(e_reg[0].v1.y))
                    begin
                        e_next[0] = e_reg[1];
                        e_next[1] = e_reg[0];
                    end
                    edge_next  = 1'b0;
                    row_next   = '0;
                    state_next = ST_FSET;
                end
                else
                begin
                    err_next = 12'(nerr);
                    wx_next  = nx;
                    wy_next  = ny;
                    row_next = nrow;
                    sp_waddr = nrow[SP_AW-1:0];
                    sp_wdata = nx;
                    sp_we    = row_ok(nrow)
                               && (cond_y || (cond_x && (sx_neg_reg == rs_reg)));
                end
            end
            ST_FSET:
            begin
                dx_next     = wi_dx;
                dy_next     = wi_dy;
                sx_neg_next = !($signed(wseg.v1.x) < $signed(wseg.v2.x));
                err_next    = 12'(wi_dx) - 12'(wi_dy);
                wx_next     = 10'(wseg.v1.x);
                wy_next     = 10'(wseg.v1.y);
                x2_next     = 10'(wseg.v2.x);
                y2_next     = 10'(wseg.v2.y);
                state_next  = ST_FPOINT;
            end
            ST_FPOINT:
            begin
                if (row_ok(row_reg))
                begin
                    sp_re      = 1'b1;
                    state_next = ST_FLIM;
                end
                else
                begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FLIM:
            begin
                lim_next = sp_q;
                cur_next = wx_reg;
                if (rs_reg)
                begin
                    sp_wdata = wx_reg + 10'sd1;
                    sp_we    = (wx_reg + 10'sd1) > sp_q;
                end
                else
                begin
                    sp_wdata = wx_reg - 10'sd1;
                    sp_we    = (wx_reg - 10'sd1) < sp_q;
                end
                state_next = ST_FRUN;
            end
            ST_FRUN:
            begin
                if (run_on)
                begin
                    fb_re         = in_pic(cur_reg, wy_reg);
                    p1_valid_next = in_pic(cur_reg, wy_reg);
                    p1_addr_next  = pix_addr(cur_reg, wy_reg);
                    cur_next      = rs_reg ? cur_reg - 10'sd1 : cur_reg + 10'sd1;
                end
                else
                begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN:
            begin
                if (!p1_valid_reg && !bl_valid)
                begin
                    if (at_end)
                    begin
                        if (!edge_reg)
                        begin
                            edge_next  = 1'b1;
                            state_next = ST_FSET;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        err_next   = 12'(nerr);
                        wx_next    = nx;
                        wy_next    = ny;
                        row_next   = nrow;
                        state_next = ST_FPOINT;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = hit_reg ? fb_q : '0;
                    clr_item_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= '0;
            pts_reg       <= '{default: '0};
            col_reg       <= '0;
            alpha_reg     <= '0;
            e_reg         <= '{default: '0};
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
            rs_reg        <= 1'b0;
            err_reg       <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            x2_reg        <= '0;
            y2_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            sx_neg_reg    <= 1'b0;
            row_reg       <= '0;
            edge_reg      <= 1'b0;
            lim_reg       <= '0;
            cur_reg       <= '0;
            clr_reg       <= '0;
            clr_item_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            p1_addr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pts_reg       <= pts_next;
            col_reg       <= col_next;
            alpha_reg     <= alpha_next;
            e_reg         <= e_next;
            prod_a_reg    <= prod_a_next;
            prod_b_reg    <= prod_b_next;
            rs_reg        <= rs_next;
            err_reg       <= err_next;
            wx_reg        <= wx_next;
            wy_reg        <= wy_next;
            x2_reg        <= x2_next;
            y2_reg        <= y2_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            sx_neg_reg    <= sx_neg_next;
            row_reg       <= row_next;
            edge_reg      <= edge_next;
            lim_reg       <= lim_next;
            cur_reg       <= cur_next;
            clr_reg       <= clr_next;
            clr_item_reg  <= clr_item_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            p1_valid_reg  <= p1_valid_next;
            p1_addr_reg   <= p1_addr_next;
        end
    end

    // pixel pipeline is empty whenever a new walk point starts
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FPOINT) |-> (!p1_valid_reg && !bl_valid))
        else $error("pixel pipeline busy at new walk point");

    // span store never read and written in one cycle
    a_span_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(sp_we && sp_re))
        else $error("span store read and write collide");

    // a result only appears after the done step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done step");

    // blend writes never overlap the clearing sweep
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !bl_valid)
        else $error("blend write during clear");

endmodule

### hw/rtl/trab_blend.sv
// alpha blend of one pixel: registered products, then sum and divide by 255
`timescale 1ns / 1ps

module trab_blend #(
    parameter int FB_AW = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [FB_AW-1:0]             in_addr,
    input  logic [trab_pkg::PIX_W-1:0]   old_pix,
    input  logic [trab_pkg::PIX_W-1:0]   paint_pix,
    input  logic [trab_pkg::CH_W-1:0]    alpha,
    output logic                         out_valid,
    output logic [FB_AW-1:0]             out_addr,
    output logic [trab_pkg::PIX_W-1:0]   out_pix
);

    logic              valid_reg;
    logic [FB_AW-1:0]  addr_reg;
    logic [15:0]       prod_old_reg [3];
    logic [15:0]       prod_col_reg [3];
    logic [7:0]        inv_alpha;

    assign inv_alpha = trab_pkg::CH_MAX - alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= in_addr;
        for (int k = 0; k < 3; k++)
        begin
            prod_old_reg[k] <= old_pix[8*k +: 8] * inv_alpha;
            prod_col_reg[k] <= paint_pix[8*k +: 8] * alpha;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            out_pix[8*k +: 8] = trab_pkg::div255({1'b0, prod_old_reg[k]}
                                                 + {1'b0, prod_col_reg[k]});
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;

endmodule
